[rtl/core/aled_pkg.sv]
// Shared types, codes and constants of the addressable LED chain driver.
package aled_pkg;

  localparam int LED_COUNT = 8;
  localparam int LED_AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 20;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_START = 2'd1,
    ACT_TICK  = 2'd2
  } action_t;

  localparam logic [CFG_IW-1:0] REG_BRIGHTNESS = 3'd0;
  localparam logic [CFG_IW-1:0] REG_ZERO_HIGH  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_ZERO_LOW   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_ONE_HIGH   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_ONE_LOW    = 3'd4;
  localparam logic [CFG_IW-1:0] REG_LATCH      = 3'd5;

  localparam logic [6:0]  BRIGHT_MAX       = 7'd100;
  localparam logic [15:0] ZERO_HIGH_RST    = 16'd165;
  localparam logic [15:0] ZERO_LOW_RST     = 16'd495;
  localparam logic [15:0] ONE_HIGH_RST     = 16'd330;
  localparam logic [15:0] ONE_LOW_RST      = 16'd330;
  localparam logic [19:0] LATCH_RST        = 20'd55000;

  // Division by one hundred as a multiply by ceil(2^22/100) and a shift by 22.
  localparam logic [15:0] DIV100_RECIP     = 16'd41944;
  localparam int          DIV100_SHIFT     = 22;

  localparam logic [1:0]  LANE_LAST        = 2'd2;
  localparam logic [2:0]  BIT_FIRST        = 3'd7;

endpackage

[rtl/core/addressable_led_chain_driver.sv]
// Top level of the addressable LED chain driver: pixel memory, byte scaling and bit timing.
//
// Each request (pixel write, frame start or one tick) is taken in one handshake, and a tick
// returns its result through an output register; a further tick waits while that result
// is not taken, but other requests keep flowing. After a frame start and after every byte
// boundary inside a frame, the input holds off while the next byte is read from the pixel
// memory (one row of green, red and blue per LED) and scaled by brightness in two multiplier
// stages; a byte spans at least sixteen ticks, so the sustained rate stays close to one
// request per cycle. Pixel rows have valid bits cleared at reset, so need no clearing pass.
module addressable_led_chain_driver (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_action,
  input  logic [2:0]                  in_pixel_index,
  input  logic [7:0]                  in_red,
  input  logic [7:0]                  in_green,
  input  logic [7:0]                  in_blue,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_data_line,
  output logic                        out_busy_res,
  output logic                        out_frame_done,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [aled_pkg::CFG_IW-1:0] cfg_index,
  input  logic [aled_pkg::CFG_DW-1:0] cfg_data
);
  import aled_pkg::*;

  logic [6:0]  brightness_r;
  logic [15:0] zero_high_r;
  logic [15:0] zero_low_r;
  logic [15:0] one_high_r;
  logic [15:0] one_low_r;
  logic [19:0] latch_r;

  logic [23:0]       pix_mem [LED_COUNT];
  logic [LED_COUNT-1:0] row_valid_r;
  logic [23:0]       rd_data_r;
  logic              rd_ok_r;

  logic [LED_AW-1:0] led_r, led_nxt;
  logic [1:0]        lane_r, lane_nxt;
  logic [2:0]        bit_pos_r, bit_pos_nxt;
  logic              low_r, low_nxt;
  logic [19:0]       tick_r, tick_nxt;
  logic              sending_r, sending_nxt;
  logic              latching_r, latching_nxt;
  logic              s1_r, s2_r;
  logic [6:0]        bright_snap_r;
  logic [14:0]       prod_r;
  logic [7:0]        shift_byte_r;

  logic              out_valid_r;
  logic              out_line_r;
  logic              out_busy_r;
  logic              out_done_r;

  logic              busy;
  logic              accept;
  logic              do_write;
  logic              do_start;
  logic              do_tick;
  logic              load;
  logic              cur_bit;
  logic [19:0]       tick_inc;
  logic [15:0]       high_lim;
  logic [15:0]       low_lim;
  logic              line;
  logic              done;
  logic [7:0]        raw_byte;
  logic [30:0]       recip_prod;

  assign busy     = sending_r | latching_r;
  assign in_ready = !(s1_r | s2_r) &&
                    (!out_valid_r || out_ready || in_action != ACT_TICK);
  assign accept   = in_valid & in_ready;
  assign do_write = accept && in_action == ACT_WRITE && !busy &&
                    32'(in_pixel_index) < LED_COUNT;
  assign do_start = accept && in_action == ACT_START && !busy;
  assign do_tick  = accept && in_action == ACT_TICK;

  assign cur_bit  = shift_byte_r[bit_pos_r];
  assign tick_inc = tick_r + 20'd1;
  assign high_lim = cur_bit ? one_high_r : zero_high_r;
  assign low_lim  = cur_bit ? one_low_r : zero_low_r;

  always_comb begin
    led_nxt      = led_r;
    lane_nxt     = lane_r;
    bit_pos_nxt  = bit_pos_r;
    low_nxt      = low_r;
    tick_nxt     = tick_r;
    sending_nxt  = sending_r;
    latching_nxt = latching_r;
    load         = 1'b0;
    line         = 1'b0;
    done         = 1'b0;
    if (do_start) begin
      sending_nxt = 1'b1;
      led_nxt     = '0;
      lane_nxt    = '0;
      bit_pos_nxt = BIT_FIRST;
      low_nxt     = 1'b0;
      tick_nxt    = '0;
      load        = 1'b1;
    end else if (do_tick) begin
      if (sending_r) begin
        tick_nxt = tick_inc;
        if (!low_r) begin
          line = 1'b1;
          if (tick_inc >= {4'd0, high_lim}) begin
            low_nxt  = 1'b1;
            tick_nxt = '0;
          end
        end else if (tick_inc >= {4'd0, low_lim}) begin
          tick_nxt = '0;
          low_nxt  = 1'b0;
          if (bit_pos_r != 3'd0) begin
            bit_pos_nxt = bit_pos_r - 3'd1;
          end else begin
            bit_pos_nxt = BIT_FIRST;
            if (lane_r != LANE_LAST) begin
              lane_nxt = lane_r + 2'd1;
              load     = 1'b1;
            end else if (led_r != LED_AW'(LED_COUNT - 1)) begin
              led_nxt  = led_r + LED_AW'(1);
              lane_nxt = '0;
              load     = 1'b1;
            end else begin
              sending_nxt  = 1'b0;
              latching_nxt = 1'b1;
              led_nxt      = '0;
              lane_nxt     = '0;
            end
          end
        end
      end else if (latching_r) begin
        tick_nxt = tick_inc;
        if (tick_inc >= latch_r) begin
          latching_nxt = 1'b0;
          tick_nxt     = '0;
          done         = 1'b1;
        end
      end
    end
  end

  always_comb begin
    case (lane_r)
      2'd0:    raw_byte = rd_data_r[7:0];
      2'd1:    raw_byte = rd_data_r[15:8];
      2'd2:    raw_byte = rd_data_r[23:16];
      default: raw_byte = '0;
    endcase
    if (!rd_ok_r) begin
      raw_byte = '0;
    end
  end

  assign recip_prod = 31'(prod_r) * 31'(DIV100_RECIP);

  always_ff @(posedge clk) begin
    if (do_write) begin
      pix_mem[LED_AW'(in_pixel_index)] <= {in_blue, in_red, in_green};
    end
    if (load) begin
      rd_data_r <= pix_mem[led_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rd_ok_r       <= row_valid_r[led_nxt];
      bright_snap_r <= brightness_r;
    end
    if (s1_r) begin
      prod_r <= 15'(raw_byte) * 15'(bright_snap_r);
    end
    if (s2_r) begin
      shift_byte_r <= recip_prod[DIV100_SHIFT +: 8];
    end
    if (do_tick) begin
      out_line_r <= line;
      out_busy_r <= busy;
      out_done_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      led_r       <= '0;
      lane_r      <= '0;
      bit_pos_r   <= BIT_FIRST;
      low_r       <= 1'b0;
      tick_r      <= '0;
      sending_r   <= 1'b0;
      latching_r  <= 1'b0;
      s1_r        <= 1'b0;
      s2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (do_write) begin
        row_valid_r[LED_AW'(in_pixel_index)] <= 1'b1;
      end
      led_r      <= led_nxt;
      lane_r     <= lane_nxt;
      bit_pos_r  <= bit_pos_nxt;
      low_r      <= low_nxt;
      tick_r     <= tick_nxt;
      sending_r  <= sending_nxt;
      latching_r <= latching_nxt;
      s1_r       <= load;
      s2_r       <= s1_r;
      if (do_tick) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= BRIGHT_MAX;
      zero_high_r  <= ZERO_HIGH_RST;
      zero_low_r   <= ZERO_LOW_RST;
      one_high_r   <= ONE_HIGH_RST;
      one_low_r    <= ONE_LOW_RST;
      latch_r      <= LATCH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BRIGHTNESS: begin
          brightness_r <= (cfg_data[6:0] > BRIGHT_MAX) ? BRIGHT_MAX : cfg_data[6:0];
        end
        REG_ZERO_HIGH: zero_high_r <= cfg_data[15:0];
        REG_ZERO_LOW:  zero_low_r  <= cfg_data[15:0];
        REG_ONE_HIGH:  one_high_r  <= cfg_data[15:0];
        REG_ONE_LOW:   one_low_r   <= cfg_data[15:0];
        REG_LATCH:     latch_r     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_line  = out_line_r;
  assign out_busy_res   = out_busy_r;
  assign out_frame_done = out_done_r;

endmodule

[tb/sv/led_chain_checker.sv]
// Checker for the LED chain driver: predicts every tick's line levels and compares them.
module led_chain_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [1:0]                  in_action,
  input  logic [2:0]                  in_pixel_index,
  input  logic [7:0]                  in_red,
  input  logic [7:0]                  in_green,
  input  logic [7:0]                  in_blue,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        out_data_line,
  input  logic                        out_busy_res,
  input  logic                        out_frame_done,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [aled_pkg::CFG_IW-1:0] cfg_index,
  input  logic [aled_pkg::CFG_DW-1:0] cfg_data,
  output int unsigned                 levels_waiting,
  output int unsigned                 mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import aled_pkg::*;

  localparam int STORE_BYTES = LED_COUNT * 3;

  typedef struct packed {
    logic data_line;
    logic busy_res;
    logic frame_done;
  } line_level_t;

  logic [7:0]  pixel_bytes [STORE_BYTES];
  logic [6:0]  bright_pct;
  logic [15:0] zero_high;
  logic [15:0] zero_low;
  logic [15:0] one_high;
  logic [15:0] one_low;
  logic [19:0] latch_len;
  int unsigned byte_ptr;
  logic [2:0]  bit_pos;
  logic [7:0]  cur_byte;
  logic        low_phase;
  logic [19:0] phase_ticks;
  logic        sending;
  logic        latching;
  line_level_t level_q [$];

  function automatic logic [7:0] scaled_pixel(int unsigned pos);
    int unsigned v;
    v = (pos < STORE_BYTES) ? int'(pixel_bytes[pos]) : 0;
    return 8'((v * int'(bright_pct)) / 100);
  endfunction

  always @(posedge clk) begin : predict
    line_level_t want;
    line_level_t got;
    logic [15:0] lim;
    logic        cur_bit;
    logic        busy;
    if (!rst_n) begin
      bright_pct = BRIGHT_MAX;
      zero_high = ZERO_HIGH_RST;
      zero_low = ZERO_LOW_RST;
      one_high = ONE_HIGH_RST;
      one_low = ONE_LOW_RST;
      latch_len = LATCH_RST;
      foreach (pixel_bytes[i]) pixel_bytes[i] = 8'd0;
      byte_ptr = 0;
      bit_pos = BIT_FIRST;
      cur_byte = 8'd0;
      low_phase = 1'b0;
      phase_ticks = 20'd0;
      sending = 1'b0;
      latching = 1'b0;
      level_q.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BRIGHTNESS: bright_pct = (cfg_data[6:0] > BRIGHT_MAX) ? BRIGHT_MAX : cfg_data[6:0];
          REG_ZERO_HIGH:  zero_high = cfg_data[15:0];
          REG_ZERO_LOW:   zero_low = cfg_data[15:0];
          REG_ONE_HIGH:   one_high = cfg_data[15:0];
          REG_ONE_LOW:    one_low = cfg_data[15:0];
          REG_LATCH:      latch_len = cfg_data[19:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        busy = sending || latching;
        case (action_t'(in_action))
          ACT_WRITE: begin
            if (!busy && int'(in_pixel_index) < LED_COUNT) begin
              pixel_bytes[int'(in_pixel_index) * 3]     = in_green;
              pixel_bytes[int'(in_pixel_index) * 3 + 1] = in_red;
              pixel_bytes[int'(in_pixel_index) * 3 + 2] = in_blue;
            end
          end
          ACT_START: begin
            if (!busy) begin
              sending = 1'b1;
              byte_ptr = 0;
              bit_pos = BIT_FIRST;
              cur_byte = scaled_pixel(0);
              low_phase = 1'b0;
              phase_ticks = 20'd0;
            end
          end
          ACT_TICK: begin
            want = '0;
            want.busy_res = busy;
            if (sending) begin
              cur_bit = cur_byte[bit_pos];
              phase_ticks = phase_ticks + 20'd1;
              if (!low_phase) begin
                lim = cur_bit ? one_high : zero_high;
                want.data_line = 1'b1;
                if (phase_ticks >= 20'(lim)) begin
                  low_phase = 1'b1;
                  phase_ticks = 20'd0;
                end
              end else begin
                lim = cur_bit ? one_low : zero_low;
                if (phase_ticks >= 20'(lim)) begin
                  phase_ticks = 20'd0;
                  low_phase = 1'b0;
                  if (bit_pos != 3'd0) begin
                    bit_pos = bit_pos - 3'd1;
                  end else begin
                    byte_ptr++;
                    bit_pos = BIT_FIRST;
                    if (byte_ptr >= STORE_BYTES) begin
                      sending = 1'b0;
                      latching = 1'b1;
                      byte_ptr = 0;
                    end else begin
                      cur_byte = scaled_pixel(byte_ptr);
                    end
                  end
                end
              end
            end else if (latching) begin
              phase_ticks = phase_ticks + 20'd1;
              if (phase_ticks >= latch_len) begin
                latching = 1'b0;
                phase_ticks = 20'd0;
                want.frame_done = 1'b1;
              end
            end
            level_q.push_back(want);
          end
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        got = '{out_data_line, out_busy_res, out_frame_done};
        if (level_q.size() == 0) begin
          $error("tick result arrived with no expected line level waiting");
          mismatch_count++;
        end else begin
          want = level_q.pop_front();
          if (got.data_line !== want.data_line) begin
            $error("data_line: expected %0b, got %0b", want.data_line, got.data_line);
            mismatch_count++;
          end
          if (got.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0b, got %0b", want.busy_res, got.busy_res);
            mismatch_count++;
          end
          if (got.frame_done !== want.frame_done) begin
            $error("frame_done: expected %0b, got %0b", want.frame_done, got.frame_done);
            mismatch_count++;
          end
        end
      end
    end
    levels_waiting <= level_q.size();
  end

endmodule

[tb/sv/tb.sv]
// Testbench top for the LED chain driver: clock, reset, stimulus, back-pressure and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aled_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 242;
  localparam int SETTLE_CYCLES = 12;
  localparam int LIMIT_CYCLES  = 400_000;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_action = 2'd0;
  logic [2:0]        in_pixel_index = 3'd0;
  logic [7:0]        in_red = 8'd0;
  logic [7:0]        in_green = 8'd0;
  logic [7:0]        in_blue = 8'd0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_data_line;
  logic              out_busy_res;
  logic              out_frame_done;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;
  int unsigned       levels_waiting;
  int unsigned       mismatch_count;
  bit                no_idle = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  addressable_led_chain_driver dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_pixel_index(in_pixel_index),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data_line (out_data_line),
    .out_busy_res  (out_busy_res),
    .out_frame_done(out_frame_done),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  led_chain_checker level_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_pixel_index(in_pixel_index),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data_line (out_data_line),
    .out_busy_res  (out_busy_res),
    .out_frame_done(out_frame_done),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .levels_waiting(levels_waiting),
    .mismatch_count(mismatch_count)
  );

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : result_backpressure
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        stall = no_idle ? 0 : $urandom_range(0, 6);
      end else if (stall != 0) begin
        stall--;
      end
      out_ready <= (stall == 0);
    end
  end

  task automatic send_request(logic [1:0] act, logic [2:0] idx,
                              logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned gap;
    in_valid <= 1'b1;
    in_action <= act;
    in_pixel_index <= idx;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    do @(posedge clk); while (!in_ready);
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (levels_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_DW-1:0] pick_bit_ticks();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 20'd65535;
    if (pick < 4) return 20'd0;
    return 20'($urandom_range(1, 3));
  endfunction

  function automatic logic [CFG_DW-1:0] pick_latch_ticks();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 20'hFFFFF;
    if (pick < 4) return 20'd0;
    return 20'($urandom_range(1, 24));
  endfunction

  function automatic logic [CFG_DW-1:0] pick_brightness();
    case ($urandom_range(0, 5))
      0: return 20'd0;
      1: return 20'd100;
      2: return 20'd127;
      3: return 20'($urandom_range(101, 127));
      default: return 20'($urandom_range(0, 100));
    endcase
  endfunction

  initial begin : stimulus
    int unsigned pick;
    logic [1:0]  act;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Idle tick, the unused action code and pixel writes at the field extremes.
    send_request(ACT_TICK, 3'd0, 8'h00, 8'h00, 8'h00);
    send_request(ACT_UNUSED, 3'd7, 8'hFF, 8'hFF, 8'hFF);
    send_request(ACT_WRITE, 3'd0, 8'h00, 8'hFF, 8'h80);
    send_request(ACT_WRITE, 3'd7, 8'hFF, 8'h00, 8'h7F);
    send_request(ACT_WRITE, 3'd3, 8'h55, 8'hAA, 8'h01);
    settle();

    // Saturating brightness, longest high times, zero low counts, longest latch.
    write_reg(REG_BRIGHTNESS, 20'd127);
    write_reg(REG_ZERO_HIGH, 20'hFFFFF);
    write_reg(REG_ONE_HIGH, 20'd65535);
    write_reg(REG_ZERO_LOW, 20'd0);
    write_reg(REG_ONE_LOW, 20'd0);
    write_reg(REG_LATCH, 20'hFFFFF);

    // A start and a pixel write while a frame is running are both dropped.
    send_request(ACT_START, 3'd0, 8'h00, 8'h00, 8'h00);
    repeat (3) send_request(ACT_TICK, 3'd0, 8'h00, 8'h00, 8'h00);
    send_request(ACT_START, 3'd5, 8'h12, 8'h34, 8'h56);
    send_request(ACT_WRITE, 3'd1, 8'hFF, 8'hFF, 8'hFF);
    send_request(ACT_TICK, 3'd0, 8'h00, 8'h00, 8'h00);
    settle();

    // Timing and brightness changed in the middle of a frame.
    write_reg(REG_ZERO_HIGH, 20'd0);
    write_reg(REG_ONE_HIGH, 20'd1);
    write_reg(REG_BRIGHTNESS, 20'd0);
    repeat (6) send_request(ACT_TICK, 3'd0, 8'h00, 8'h00, 8'h00);
    settle();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_reg(CFG_IW'($urandom_range(0, 7)), CFG_DW'($urandom_range(0, 20'hFFFFF)));
      write_reg(REG_BRIGHTNESS, pick_brightness());
      write_reg(REG_ZERO_HIGH, pick_bit_ticks());
      write_reg(REG_ZERO_LOW, pick_bit_ticks());
      write_reg(REG_ONE_HIGH, pick_bit_ticks());
      write_reg(REG_ONE_LOW, pick_bit_ticks());
      write_reg(REG_LATCH, pick_latch_ticks());
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 78) act = ACT_TICK;
        else if (pick < 90) act = ACT_WRITE;
        else if (pick < 96) act = ACT_START;
        else act = ACT_UNUSED;
        send_request(act, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
